FILE: sv/ordered_list_engine_core_assert.svh
`ifndef ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define OLL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define OLL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/oll_pkg.sv
package oll_pkg;

  localparam int VAL_W    = 32;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [2:0]          sel_t;

  localparam op_t OP_INS_FIRST  = 3'd0;
  localparam op_t OP_INS_LAST   = 3'd1;
  localparam op_t OP_INS_BEFORE = 3'd2;
  localparam op_t OP_INS_AFTER  = 3'd3;
  localparam op_t OP_DEL_FIRST  = 3'd4;
  localparam op_t OP_DEL_LAST   = 3'd5;
  localparam op_t OP_DEL_MATCH  = 3'd6;
  localparam op_t OP_NONE       = 3'd7;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  // Where the edit point of the list sits.
  localparam sel_t SEL_FRONT = 3'd0; // entry 0
  localparam sel_t SEL_BACK  = 3'd1; // entry count (append)
  localparam sel_t SEL_TAIL  = 3'd2; // entry count-1
  localparam sel_t SEL_MATCH = 3'd3; // first match
  localparam sel_t SEL_AFTER = 3'd4; // one past first match

  typedef struct packed {
    logic ins;
    logic del;
    sel_t sel;
  } ctrl_t;

  typedef struct packed {
    logic seen;   // a match lies at or left of this point
    logic first;  // this cell holds the first match
    logic ge;     // this cell is at or right of the edit point
  } link_t;

endpackage

FILE: sv/ordered_list_engine_core.sv
// Result: registered in the execute state, which waits until the output register is free.
// Transactions: one in flight at a time; the key compare is registered as a transaction is
//   accepted, then the cell chain shifts in the execute state before a new one is taken.
// Reset: synchronous, active high; clears the entry count, handshake state and
//   output valid. Entry storage is not cleared: only entries below the count are read.
module ordered_list_engine_core import oll_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         op,
  input  logic signed [VAL_W-1:0] new_value,
  input  logic signed [VAL_W-1:0] match_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     status,
  output logic signed [VAL_W-1:0] removed_value,
  output logic [LEN_W-1:0]        length
);

  `include "ordered_list_engine_core_assert.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  // Two-step sequencer: idle (taking a transaction) or executing it.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                    state;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  op_t                     op_q;
  logic signed [VAL_W-1:0] nv_q;

  logic    in_fire;
  logic    exec;
  logic    full;
  logic    empty;
  logic    found;
  status_t st_calc;
  ctrl_t   ctrl;

  logic signed [VAL_W-1:0] val   [CAPACITY];
  link_t                   links [CAPACITY+1];
  logic [VAL_W-1:0]        rems  [CAPACITY+1];
  logic [CNT_W+LEN_W-1:0]  len_wide;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid & in_ready;
  // Execute only once the output register can take the result.
  assign exec     = (state == S_EXEC) && (!out_valid || out_ready);

  assign full  = (count == CAP_C);
  assign empty = (count == '0);
  assign found = links[CAPACITY].seen;

  // Decode: status first, then what the chain does. Nothing moves unless status is ok.
  always_comb begin
    st_calc  = ST_OK;
    ctrl.ins = 1'b0;
    ctrl.del = 1'b0;
    ctrl.sel = SEL_FRONT;
    unique case (op_q) inside
      OP_INS_FIRST, OP_INS_LAST: begin
        ctrl.sel = (op_q == OP_INS_FIRST) ? SEL_FRONT : SEL_BACK;
        if (full) begin
          st_calc = ST_FULL;
        end else begin
          ctrl.ins = 1'b1;
        end
      end
      OP_INS_BEFORE, OP_INS_AFTER: begin
        ctrl.sel = (op_q == OP_INS_BEFORE) ? SEL_MATCH : SEL_AFTER;
        if (empty) begin
          st_calc = ST_EMPTY;
        end else if (full) begin
          st_calc = ST_FULL;
        end else if (!found) begin
          st_calc = ST_NOT_FOUND;
        end else begin
          ctrl.ins = 1'b1;
        end
      end
      OP_DEL_FIRST, OP_DEL_LAST: begin
        ctrl.sel = (op_q == OP_DEL_FIRST) ? SEL_FRONT : SEL_TAIL;
        if (empty) begin
          st_calc = ST_EMPTY;
        end else begin
          ctrl.del = 1'b1;
        end
      end
      OP_DEL_MATCH: begin
        ctrl.sel = SEL_MATCH;
        if (empty) begin
          st_calc = ST_EMPTY;
        end else if (!found) begin
          st_calc = ST_NOT_FOUND;
        end else begin
          ctrl.del = 1'b1;
        end
      end
      default: begin
        // unused code: no change
      end
    endcase

    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.del) begin
      count_next = count - CNT_W'(1);
    end
    len_wide = {{LEN_W{1'b0}}, count_next};
  end

  // Cell chain: entry 0 at the front. On exec, cells at or right of the edit point shift:
  // right on insert (the new value enters at the edit point), left on delete.
  assign links[0] = '0;
  assign rems[0]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_v;
    logic signed [VAL_W-1:0] right_v;

    if (i == 0) begin : g_head
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = val[i+1];
    end

    oll_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .load        (in_fire),
      .key         (match_value),
      .exec        (exec),
      .ctrl        (ctrl),
      .count       (count),
      .new_value   (nv_q),
      .left_value  (left_v),
      .right_value (right_v),
      .link_in     (links[i]),
      .rem_in      (rems[i]),
      .value       (val[i]),
      .link_out    (links[i+1]),
      .rem_out     (rems[i+1])
    );
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        state <= S_EXEC;
      end else if (exec) begin
        state <= S_IDLE;
      end
      if (exec) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Transaction and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q <= op;
      nv_q <= new_value;
    end
    if (exec) begin
      status        <= st_calc;
      removed_value <= ctrl.del ? rems[CAPACITY] : '0;
      length        <= len_wide[LEN_W-1:0];
    end
  end

  `OLL_ASSERT_NOW(a_count_bound, 1'b1, count <= CAP_C, "entry count above capacity")
  `OLL_ASSERT_NEXT(a_fire_exec, in_fire, state == S_EXEC && !in_ready, "accept did not start execution")
  `OLL_ASSERT_NEXT(a_ins_grow, exec && ctrl.ins, count == $past(count) + CNT_W'(1), "insert did not grow list")
  `OLL_ASSERT_NEXT(a_refuse_hold, exec && st_calc != ST_OK, count == $past(count), "refused transaction changed count")
  `OLL_ASSERT_NOW(a_ok_moves, exec && st_calc == ST_OK && op_q != OP_NONE, ctrl.ins || ctrl.del, "ok status without edit")

endmodule

FILE: sv/oll_cell.sv
module oll_cell import oll_pkg::*; #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic                    clk,
  input  logic                    load,
  input  logic signed [VAL_W-1:0] key,
  input  logic                    exec,
  input  ctrl_t                   ctrl,
  input  logic [CNT_W-1:0]        count,
  input  logic signed [VAL_W-1:0] new_value,
  input  logic signed [VAL_W-1:0] left_value,
  input  logic signed [VAL_W-1:0] right_value,
  input  link_t                   link_in,
  input  logic [VAL_W-1:0]        rem_in,
  output logic signed [VAL_W-1:0] value,
  output link_t                   link_out,
  output logic [VAL_W-1:0]        rem_out
);

  localparam logic [CNT_W-1:0] IDX  = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] IDX1 = CNT_W'(INDEX + 1);
  localparam logic             IS_HEAD = (INDEX == 0);

  logic hit;
  logic first_here;
  logic start;

  always_comb begin
    first_here = hit & ~link_in.seen;
    case (ctrl.sel)
      SEL_FRONT: start = IS_HEAD;
      SEL_BACK:  start = (count == IDX);
      SEL_TAIL:  start = (count == IDX1);
      SEL_MATCH: start = first_here;
      SEL_AFTER: start = link_in.first;
      default:   start = 1'b0;
    endcase
    link_out.seen  = link_in.seen | hit;
    link_out.first = first_here;
    link_out.ge    = link_in.ge | start;
    rem_out        = rem_in | (start ? value : '0);
  end

  // Compare against the key as the transaction enters; only live entries count.
  always_ff @(posedge clk) begin
    if (load) begin
      hit <= (value == key) && (IDX < count);
    end
  end

  always_ff @(posedge clk) begin
    if (exec && link_out.ge) begin
      if (ctrl.ins) begin
        value <= start ? new_value : left_value;
      end else if (ctrl.del) begin
        value <= right_value;
      end
    end
  end

endmodule
